// File: sv/sitda_pkg.sv
`default_nettype none

package sitda_pkg;

    // Widths of the input and result fields.
    localparam int NUM_W   = 25;
    localparam int LEN_W   = 8;
    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 4;

    // Largest number of decimal digits a magnitude may have.
    localparam int MAX_DIGITS = 7;

    // Digits needed to hold the largest 25-bit magnitude (2^24 has eight digits).
    localparam int MAG_DIGITS = 8;

    // The BCD register keeps at least one digit above the allowed ones for the range check.
    localparam int BCD_DIGITS = (MAX_DIGITS + 1 > MAG_DIGITS) ? MAX_DIGITS + 1 : MAG_DIGITS;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int IDX_W      = (BCD_DIGITS > 1) ? $clog2(BCD_DIGITS) : 1;
    localparam int DCNT_W     = $clog2(BCD_DIGITS + 1);
    localparam int STEP_W     = $clog2(NUM_W);

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

    typedef logic [BCD_W-1:0] bcd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_CHECK,
        ST_EMIT
    } state_t;

    // Double-dabble correction: add three to every digit of five or more.
    function automatic bcd_t add_three(input bcd_t value);
        bcd_t res;
        res = value;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (value[4*i +: 4] >= 4'd5)
            begin
                res[4*i +: 4] = value[4*i +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: sv/signed_int_to_decimal_ascii_core.sv
// Channel | Direction | Handshake          | Word fields
// --------+-----------+--------------------+------------------------------------------------
// in      | input     | in_valid/in_ready   | number_in[24:0] signed, max_length[7:0]
// out     | output    | out_valid/out_ready | ascii_char[7:0], last_char, failed, chars_written[3:0]
//
// One word is converted at a time: an accept step, bit-serial double dabble (one
// magnitude bit per cycle), a check step, then 1 to 8 output words, one per cycle
// while the output is not stalled.
// The shift-and-correct loop over the BCD register sets the conversion time.
// Reset (rst_n, asynchronous, active low) returns the block to idle with no word held.
// A stalled output holds its word; the next character waits until it is taken.
`default_nettype none

module signed_int_to_decimal_ascii_core (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire signed [sitda_pkg::NUM_W-1:0]   number_in,
    input  wire        [sitda_pkg::LEN_W-1:0]   max_length,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic       [sitda_pkg::CHAR_W-1:0]  ascii_char,
    output logic                                last_char,
    output logic                                failed,
    output logic       [sitda_pkg::COUNT_W-1:0] chars_written
);

    import sitda_pkg::*;

    // Control state.
    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                out_valid_reg, out_valid_next;

    // Working registers.
    logic [NUM_W-1:0]    mag_reg, mag_next;
    bcd_t                bcd_reg, bcd_next;
    logic                neg_reg, neg_next;
    logic [LEN_W-1:0]    room_reg, room_next;
    logic                err_reg, err_next;
    logic                sign_pend_reg, sign_pend_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [COUNT_W-1:0]  total_reg, total_next;

    // Output word registers.
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                last_reg, last_next;
    logic                fail_reg, fail_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    // Next state and datapath.
    always_comb
    begin
        logic [DCNT_W-1:0] ndig;
        logic              too_big;
        logic              load;
        logic [3:0]        digit;
        bcd_t              adj;

        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        room_next      = room_reg;
        err_next       = err_reg;
        sign_pend_next = sign_pend_reg;
        idx_next       = idx_reg;
        total_next     = total_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        fail_next      = fail_reg;
        count_next     = count_reg;

        // Digit count and range check over the finished BCD value.
        ndig    = DCNT_W'(1);
        too_big = 1'b0;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
            begin
                ndig = DCNT_W'(i + 1);
                if (i >= MAX_DIGITS)
                begin
                    too_big = 1'b1;
                end
            end
        end

        adj   = add_three(bcd_reg);
        digit = bcd_reg[4*idx_reg +: 4];
        load  = !out_valid_reg || out_ready;

        // The output word is dropped once taken, unless a new one replaces it.
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next   = number_in[NUM_W-1];
                    mag_next   = number_in[NUM_W-1] ? (~number_in + NUM_W'(1)) : number_in;
                    room_next  = max_length;
                    bcd_next   = '0;
                    step_next  = '0;
                    state_next = ST_CONV;
                end
            end

            ST_CONV:
            begin
                // Correct, then shift one magnitude bit into the BCD register.
                bcd_next  = {adj[BCD_W-2:0], mag_reg[NUM_W-1]};
                mag_next  = {mag_reg[NUM_W-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(NUM_W - 1))
                begin
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                err_next = (room_reg == '0) || too_big ||
                           (LEN_W'(ndig) > (room_reg - LEN_W'(neg_reg)));
                sign_pend_next = neg_reg;
                idx_next       = IDX_W'(ndig - DCNT_W'(1));
                total_next     = COUNT_W'(ndig) + COUNT_W'(neg_reg);
                state_next     = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    if (err_reg)
                    begin
                        char_next  = '0;
                        last_next  = 1'b1;
                        fail_next  = 1'b1;
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    else if (sign_pend_reg)
                    begin
                        char_next      = CHAR_MINUS;
                        last_next      = 1'b0;
                        fail_next      = 1'b0;
                        count_next     = '0;
                        sign_pend_next = 1'b0;
                    end
                    else
                    begin
                        char_next = CHAR_ZERO + CHAR_W'(digit);
                        fail_next = 1'b0;
                        if (idx_reg == '0)
                        begin
                            last_next  = 1'b1;
                            count_next = total_reg;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            last_next  = 1'b0;
                            count_next = '0;
                            idx_next   = idx_reg - IDX_W'(1);
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        bcd_reg       <= bcd_next;
        neg_reg       <= neg_next;
        room_reg      <= room_next;
        err_reg       <= err_next;
        sign_pend_reg <= sign_pend_next;
        idx_reg       <= idx_next;
        total_reg     <= total_next;
        char_reg      <= char_next;
        last_reg      <= last_next;
        fail_reg      <= fail_next;
        count_reg     <= count_next;
    end

    // Ports.
    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign ascii_char    = char_reg;
    assign last_char     = last_reg;
    assign failed        = fail_reg;
    assign chars_written = count_reg;

endmodule

`default_nettype wire

// File: sv/sitda_checker.sv
`default_nettype none

module sitda_checker (
    input wire                                 clk,
    input wire                                 rst_n,
    input wire                                 in_valid,
    input wire                                 in_ready,
    input wire                                 out_valid,
    input wire                                 out_ready,
    input wire        [sitda_pkg::CHAR_W-1:0]  ascii_char,
    input wire                                 last_char,
    input wire                                 failed,
    input wire        [sitda_pkg::COUNT_W-1:0] chars_written
);

    import sitda_pkg::*;

    // A stalled output word keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ascii_char) && $stable(last_char)
            && $stable(failed) && $stable(chars_written))
        else $error("output word changed while stalled");

    // An error word is a lone final word with nothing written.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && failed |-> last_char && chars_written == '0 && ascii_char == '0)
        else $error("malformed error word");

    // Words before the final one carry no count and no error.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_char |-> chars_written == '0 && !failed)
        else $error("count or error on a word that is not final");

    // A successful conversion writes at least one character.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_char && !failed |-> chars_written != '0)
        else $error("successful conversion reports no characters");

    // Only one item is converted at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after an accept");

endmodule

bind signed_int_to_decimal_ascii_core sitda_checker u_sitda_checker (.*);

`default_nettype wire
